[rtl/assert_macros.svh]
// Assertion macros shared by the PLM remap flux block.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define PLMRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define PLMRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/plmrf_pkg.sv]
// Shared types and constants of the PLM remap flux block.
// No dependencies; every other file but assert_macros.svh refers to it by scoped names.
package plmrf_pkg;

  localparam int SAMPLE_W = 32;   // sample and result width
  localparam int SHIFT_W  = 16;   // Q1.15 shift fraction
  localparam int SLOPE_W  = 35;   // twice the limited slope, signed
  localparam int DMAG_W   = 33;   // magnitude of the above
  localparam int COEF_W   = 16;   // (1 -/+ eps) in Q1.15, 0..32768
  localparam int NMAG_W   = 50;   // magnitude of the pre-scale numerator
  localparam int PROD_W   = COEF_W + NMAG_W;
  localparam int SAT_W    = 35;   // width fed to the saturator
  localparam int HALF_SHIFT  = 17;
  localparam int ROUND_SHIFT = 32;

  localparam logic [1:0] FILL_FULL = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 32'sh8000_0000;

  // Work item handed from front to back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] center;
    logic signed [SLOPE_W-1:0]  slope2;
    logic signed [SAMPLE_W-1:0] home;
    logic                       rem_valid;
    logic                       last;
  } qent_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [2:0] {
    B_LOAD,
    B_NSUM,
    B_MUL2,
    B_ROUND,
    B_EMIT
  } back_state_t;

endpackage

[rtl/plmrf_in_if.sv]
// Input sample channel of the PLM remap flux block.
// Depends on plmrf_pkg for the sample width.
interface plmrf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [plmrf_pkg::SAMPLE_W-1:0] sample;
  logic                                 row_end;

  modport source (output valid, sample, row_end, input ready);
  modport sink   (input valid, sample, row_end, output ready);
endinterface

[rtl/plmrf_out_if.sv]
// Result channel of the PLM remap flux block.
// Depends on plmrf_pkg for the sample width.
interface plmrf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [plmrf_pkg::SAMPLE_W-1:0] flux;
  logic signed [plmrf_pkg::SAMPLE_W-1:0] remapped_value;
  logic                                 remapped_valid;
  logic                                 last;

  modport source (output valid, flux, remapped_value, remapped_valid, last, input ready);
  modport sink   (input valid, flux, remapped_value, remapped_valid, last, output ready);
endinterface

[rtl/plmrf_front.sv]
// Front end: sample window, fill tracking and MC-limited slope.
// Depends on plmrf_pkg and plmrf_in_if; feeds plmrf_queue.
module plmrf_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  plmrf_in_if.sink                              in_ch,
  input  logic signed [plmrf_pkg::SHIFT_W-1:0]  shift,
  input  plmrf_pkg::qstat_t                     q_stat,
  output logic                                  q_push,
  output plmrf_pkg::qent_t                      q_wdata
);

  logic signed [plmrf_pkg::SAMPLE_W-1:0] win_r [3];
  logic signed [plmrf_pkg::SAMPLE_W-1:0] dcell_r;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic       pend_r;
  logic       last_r;
  logic       pvalid_r;
  logic       accept;
  logic       full_win;
  logic       go;
  logic       shift_pos;

  logic signed [plmrf_pkg::SAMPLE_W:0] dl, dr, dc;
  logic [plmrf_pkg::SAMPLE_W:0]        al, ar, adc, amin, m;
  logic [plmrf_pkg::SLOPE_W-1:0]       lim, adc_x, m_x;
  logic                                same;
  logic signed [plmrf_pkg::SLOPE_W-1:0] slope2;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !pend_r;
  assign full_win  = (fill_r == plmrf_pkg::FILL_FULL);
  assign go        = !full_win || !q_stat.full;
  assign q_push    = pend_r && full_win && !q_stat.full;
  assign shift_pos = !shift[plmrf_pkg::SHIFT_W-1] && (shift != '0);
  assign fill_nxt  = (fill_r == plmrf_pkg::FILL_FULL) ? fill_r : fill_r + 2'd1;

  // limited slope of the window centre, times two
  always_comb begin
    dl  = {win_r[1][plmrf_pkg::SAMPLE_W-1], win_r[1]} - {win_r[0][plmrf_pkg::SAMPLE_W-1], win_r[0]};
    dr  = {win_r[2][plmrf_pkg::SAMPLE_W-1], win_r[2]} - {win_r[1][plmrf_pkg::SAMPLE_W-1], win_r[1]};
    dc  = {win_r[2][plmrf_pkg::SAMPLE_W-1], win_r[2]} - {win_r[0][plmrf_pkg::SAMPLE_W-1], win_r[0]};
    al  = dl[plmrf_pkg::SAMPLE_W] ? 33'(-dl) : 33'(dl);
    ar  = dr[plmrf_pkg::SAMPLE_W] ? 33'(-dr) : 33'(dr);
    adc = dc[plmrf_pkg::SAMPLE_W] ? 33'(-dc) : 33'(dc);
    same = (!dl[plmrf_pkg::SAMPLE_W] && (dl != '0) && !dr[plmrf_pkg::SAMPLE_W] && (dr != '0))
        || (dl[plmrf_pkg::SAMPLE_W] && dr[plmrf_pkg::SAMPLE_W]);
    amin  = (al < ar) ? al : ar;
    lim   = {amin, 2'b00};
    adc_x = {2'b00, adc};
    m_x   = (adc_x < lim) ? adc_x : lim;
    m     = m_x[plmrf_pkg::DMAG_W-1:0];
    if (!same) begin
      slope2 = '0;
    end else if (dc[plmrf_pkg::SAMPLE_W]) begin
      slope2 = -$signed({2'b00, m});
    end else begin
      slope2 = $signed({2'b00, m});
    end
  end

  always_comb begin
    q_wdata.center    = win_r[1];
    q_wdata.slope2    = slope2;
    q_wdata.home      = shift_pos ? win_r[1] : dcell_r;
    q_wdata.rem_valid = pvalid_r;
    q_wdata.last      = last_r;
  end

  // control: one sample in flight; row end clears the window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      pend_r   <= 1'b0;
      pvalid_r <= 1'b0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      pend_r <= 1'b1;
    end else if (pend_r && go) begin
      pend_r <= 1'b0;
      if (q_push) begin
        pvalid_r <= 1'b1;
      end
      if (last_r) begin
        fill_r   <= '0;
        pvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= in_ch.sample;
      last_r   <= in_ch.row_end;
    end
    if (q_push) begin
      dcell_r <= win_r[1];
    end
  end

endmodule

[rtl/plmrf_queue.sv]
// Two-entry queue between front and back end.
// Depends on plmrf_pkg for the entry and status types.
module plmrf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  plmrf_pkg::qent_t  wdata,
  input  logic              pop,
  output plmrf_pkg::qent_t  rdata,
  output plmrf_pkg::qstat_t stat
);

  plmrf_pkg::qent_t ent_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;

  assign rdata      = ent_r[rptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= wdata;
    end
  end

endmodule

[rtl/plmrf_back.sv]
// Back end: flux and remapped value on one shared 16x50 multiplier.
// Depends on plmrf_pkg and plmrf_out_if; drains plmrf_queue.
module plmrf_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [plmrf_pkg::SHIFT_W-1:0]  shift,
  input  plmrf_pkg::qent_t                      q_rdata,
  input  plmrf_pkg::qstat_t                     q_stat,
  output logic                                  q_pop,
  plmrf_out_if.source                           out_ch
);

  function automatic logic signed [plmrf_pkg::SAMPLE_W-1:0] sat35(
    input logic signed [plmrf_pkg::SAT_W-1:0] x
  );
    logic signed [plmrf_pkg::SAMPLE_W-1:0] res;
    if (x[plmrf_pkg::SAT_W-1:plmrf_pkg::SAMPLE_W-1] == {4{x[plmrf_pkg::SAT_W-1]}}) begin
      res = x[plmrf_pkg::SAMPLE_W-1:0];
    end else if (x[plmrf_pkg::SAT_W-1]) begin
      res = plmrf_pkg::SAT_MIN;
    end else begin
      res = plmrf_pkg::SAT_MAX;
    end
    return res;
  endfunction

  plmrf_pkg::back_state_t st_r, st_nxt;
  plmrf_pkg::qent_t       ent_r;

  logic [plmrf_pkg::PROD_W-1:0]         prod_r;
  logic [plmrf_pkg::NMAG_W-1:0]         nmag_r;
  logic                                 nneg_r;
  logic signed [plmrf_pkg::SAMPLE_W-1:0] f_r, pflux_r;
  logic                                 out_vld_r;
  logic signed [plmrf_pkg::SAMPLE_W-1:0] flux_r, rem_r;
  logic                                 rvalid_r, last_r;

  logic                                 emit_go, take;
  logic                                 e_pos, e_neg;
  logic [plmrf_pkg::COEF_W-1:0]         emag, coef;
  logic signed [plmrf_pkg::SHIFT_W:0]   e17, coef17, emag17;
  logic [plmrf_pkg::COEF_W-1:0]         mul_a;
  logic [plmrf_pkg::NMAG_W-1:0]         mul_b;
  logic [plmrf_pkg::PROD_W-1:0]         mul_p;
  logic signed [plmrf_pkg::SLOPE_W-1:0] dabs;

  logic signed [plmrf_pkg::NMAG_W:0]    cen_x, term, n, nabs;
  logic                                 tneg;
  logic [plmrf_pkg::PROD_W:0]           rnd;
  logic [plmrf_pkg::PROD_W-plmrf_pkg::ROUND_SHIFT-1:0] r;
  logic signed [plmrf_pkg::SAT_W-1:0]   fs, rem_sum;
  logic signed [plmrf_pkg::SAMPLE_W-1:0] f_nxt, rem_nxt;

  // shift fraction terms
  always_comb begin
    e_neg  = shift[plmrf_pkg::SHIFT_W-1];
    e_pos  = !e_neg && (shift != '0);
    e17    = {shift[plmrf_pkg::SHIFT_W-1], shift};
    emag17 = e_neg ? -e17 : e17;
    emag   = emag17[plmrf_pkg::COEF_W-1:0];
    coef17 = e_pos ? (17'sd32768 - e17) : (17'sd32768 + e17);
    coef   = coef17[plmrf_pkg::COEF_W-1:0];
    dabs   = q_rdata.slope2[plmrf_pkg::SLOPE_W-1] ? -q_rdata.slope2 : q_rdata.slope2;
  end

  // FSM outputs and multiplier operand select
  always_comb begin
    emit_go = (st_r == plmrf_pkg::B_EMIT) && (!out_vld_r || out_ch.ready);
    take    = ((st_r == plmrf_pkg::B_LOAD) || emit_go) && !q_stat.empty;
    q_pop   = take;
    if (st_r == plmrf_pkg::B_MUL2) begin
      mul_a = emag;
      mul_b = nmag_r;
    end else begin
      mul_a = coef;
      mul_b = {{(plmrf_pkg::NMAG_W-plmrf_pkg::DMAG_W){1'b0}}, dabs[plmrf_pkg::DMAG_W-1:0]};
    end
  end

  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    case (st_r)
      plmrf_pkg::B_LOAD:  st_nxt = q_stat.empty ? plmrf_pkg::B_LOAD : plmrf_pkg::B_NSUM;
      plmrf_pkg::B_NSUM:  st_nxt = plmrf_pkg::B_MUL2;
      plmrf_pkg::B_MUL2:  st_nxt = plmrf_pkg::B_ROUND;
      plmrf_pkg::B_ROUND: st_nxt = plmrf_pkg::B_EMIT;
      plmrf_pkg::B_EMIT: begin
        if (!emit_go) begin
          st_nxt = plmrf_pkg::B_EMIT;
        end else if (!q_stat.empty) begin
          st_nxt = plmrf_pkg::B_NSUM;
        end else begin
          st_nxt = plmrf_pkg::B_LOAD;
        end
      end
      default: st_nxt = plmrf_pkg::B_LOAD;
    endcase
  end

  // numerator, rounding, remap sum
  always_comb begin
    cen_x = {{2{ent_r.center[plmrf_pkg::SAMPLE_W-1]}}, ent_r.center,
             {plmrf_pkg::HALF_SHIFT{1'b0}}};
    term  = $signed({2'b00, prod_r[plmrf_pkg::NMAG_W-2:0]});
    tneg  = ent_r.slope2[plmrf_pkg::SLOPE_W-1] ^ !e_pos;
    n     = tneg ? cen_x - term : cen_x + term;
    nabs  = n[plmrf_pkg::NMAG_W] ? -n : n;
    rnd   = {1'b0, prod_r} + ({{plmrf_pkg::PROD_W{1'b0}}, 1'b1} << (plmrf_pkg::ROUND_SHIFT - 1));
    r     = rnd[plmrf_pkg::PROD_W-1:plmrf_pkg::ROUND_SHIFT];
    fs    = (e_neg ^ nneg_r) ? -$signed({1'b0, r}) : $signed({1'b0, r});
    f_nxt = sat35(fs);
    rem_sum = {{3{ent_r.home[plmrf_pkg::SAMPLE_W-1]}}, ent_r.home}
            - {{3{f_r[plmrf_pkg::SAMPLE_W-1]}}, f_r}
            + {{3{pflux_r[plmrf_pkg::SAMPLE_W-1]}}, pflux_r};
    rem_nxt = ent_r.rem_valid ? sat35(rem_sum) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= plmrf_pkg::B_LOAD;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= q_rdata;
    end
    if (take || (st_r == plmrf_pkg::B_MUL2)) begin
      prod_r <= mul_p;
    end
    if (st_r == plmrf_pkg::B_NSUM) begin
      nmag_r <= nabs[plmrf_pkg::NMAG_W-1:0];
      nneg_r <= n[plmrf_pkg::NMAG_W];
    end
    if (st_r == plmrf_pkg::B_ROUND) begin
      f_r <= f_nxt;
    end
    if (emit_go) begin
      flux_r   <= f_r;
      rem_r    <= rem_nxt;
      rvalid_r <= ent_r.rem_valid;
      last_r   <= ent_r.last;
      pflux_r  <= ent_r.last ? '0 : f_r;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.flux           = flux_r;
  assign out_ch.remapped_value = rem_r;
  assign out_ch.remapped_valid = rvalid_r;
  assign out_ch.last           = last_r;

endmodule

[rtl/plm_limited_remap_flux_unit.sv]
// Top level of the PLM remap flux block: config register, front, queue, back.
// Depends on plmrf_pkg, plmrf_in_if, plmrf_out_if, plmrf_front, plmrf_queue,
// plmrf_back and assert_macros.svh.
//
// Usage:
//  - in_ch carries one row sample per beat (sample, row_end); row_end marks the
//    row's last sample, after which the window and the carried flux are cleared.
//  - out_ch gives one beat per sample once three samples of the row are in:
//    the limited remap flux of the window centre and, from the second result of
//    a row on, the remapped neighbor cell (remapped_valid high).
//  - cfg_wr_en / cfg_wr_data write the Q1.15 shift fraction; write only while
//    the block is idle. Its sign picks the upwind side.
//  - Front holds one sample at a time (ready low while it is pending); back
//    produces each result in steps (pop + slope multiply, numerator, flux
//    multiply, round/saturate), paced by the single shared multiplier, and
//    takes a new queue entry only when idle or as it emits the current result.
//  - A two-entry queue sits between front and back, and the result sits in an
//    output register, so a stalled receiver only holds the back end; the front
//    keeps accepting until the queue fills.
//  - Synchronous reset clears the shift fraction, window fill, queue and FSM.
`include "assert_macros.svh"

module plm_limited_remap_flux_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  plmrf_in_if.sink                             in_ch,
  plmrf_out_if.source                          out_ch,
  input  logic                                 cfg_wr_en,
  input  logic signed [plmrf_pkg::SHIFT_W-1:0] cfg_wr_data
);

  logic signed [plmrf_pkg::SHIFT_W-1:0] shift_r;
  logic                                 q_push;
  logic                                 q_pop;
  plmrf_pkg::qent_t                     q_wdata;
  plmrf_pkg::qent_t                     q_rdata;
  plmrf_pkg::qstat_t                    q_stat;

  // shift fraction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else if (cfg_wr_en) begin
      shift_r <= cfg_wr_data;
    end
  end

  // window and slope
  plmrf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .shift   (shift_r),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  plmrf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // flux, remap and output register
  plmrf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift   (shift_r),
    .q_rdata (q_rdata),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  `PLMRF_ASSERT_IMP(a_q_no_overflow, q_push, !q_stat.full, "queue push while full")
  `PLMRF_ASSERT_IMP(a_q_no_underflow, q_pop, !q_stat.empty, "queue pop while empty")
  `PLMRF_ASSERT_NXT(a_one_in_front, in_ch.valid && in_ch.ready, !in_ch.ready, "front took two beats")
  `PLMRF_ASSERT_IMP(a_rem_zero, out_ch.valid && !out_ch.remapped_valid, out_ch.remapped_value == '0, "remap value without valid")

endmodule
